// File: rtl/core/emr_pkg.sv
package emr_pkg;

    localparam int SINE_TABLE_ENTRIES = 1024;

    localparam int ELEM_W    = 18;
    localparam int ANGLE_W   = 16;
    localparam int MAG_W     = 17;
    localparam int TRIG_W    = 18;
    localparam int PROD_W    = ELEM_W + TRIG_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int RND_W     = SUM_W + 1 - 16;
    localparam int PHASE_W   = 15;
    localparam int TAB_DEPTH = SINE_TABLE_ENTRIES + 1;
    localparam int TAB_IDX_W = $clog2(TAB_DEPTH);
    localparam int IDXP_W    = PHASE_W + TAB_IDX_W + 1;
    localparam int N_STAGES  = 9;

    typedef logic signed [ELEM_W-1:0] t_elem;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic [MAG_W-1:0]         t_mag;
    typedef logic [TAB_IDX_W-1:0]     t_tab_idx;
    typedef logic [ANGLE_W-1:0]       t_angle;

    typedef t_mag t_sine_tab [0:SINE_TABLE_ENTRIES];

    typedef struct packed {
        t_tab_idx idx;
        logic     neg;
    } t_lookup;

    typedef struct packed {
        logic prod;
        logic sum;
    } t_plane_en;

    typedef struct packed {
        logic      idx;
        logic      rom;
        t_plane_en px;
        t_plane_en py;
        t_plane_en pz;
    } t_pipe_en;

    // quarter-wave entry k, Q1.16, Taylor series in Q30
    function automatic t_mag sine_entry(int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        rnd;
        int unsigned        n;
        x    = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (n = 1; n < 64; n++) begin
            if (term != 64'd0) begin
                term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                if (n[0]) begin
                    sum = sum - $signed(term);
                end else begin
                    sum = sum + $signed(term);
                end
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        rnd = ($unsigned(sum) + 64'd8192) >> 14;
        return rnd[MAG_W-1:0];
    endfunction

    function automatic t_sine_tab build_sine_table();
        t_sine_tab t;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            t[k] = sine_entry(k);
        end
        return t;
    endfunction

    localparam t_sine_tab SINE_TAB = build_sine_table();

    function automatic t_tab_idx table_index(logic [PHASE_W-1:0] v);
        logic [IDXP_W-1:0] p;
        p = IDXP_W'(v) * IDXP_W'(SINE_TABLE_ENTRIES) + IDXP_W'(8192);
        return p[TAB_IDX_W+13:14];
    endfunction

    function automatic t_lookup sine_lookup(t_angle a);
        logic [PHASE_W-1:0] p;
        logic [PHASE_W-1:0] v;
        t_lookup            l;
        p = {1'b0, a[13:0]};
        v = a[14] ? PHASE_W'(15'd16384 - p) : p;
        l.idx = table_index(v);
        l.neg = a[15];
        return l;
    endfunction

endpackage

// File: rtl/core/emr_ram.sv
module emr_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: rtl/core/emr_trig.sv
module emr_trig (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  emr_pkg::t_pipe_en     i_en,
    input  logic [emr_pkg::ANGLE_W-1:0] i_angle_x,
    input  logic [emr_pkg::ANGLE_W-1:0] i_angle_y,
    input  logic [emr_pkg::ANGLE_W-1:0] i_angle_z,
    output logic                  o_ready,
    output logic signed [emr_pkg::TRIG_W-1:0] o_cos_x,
    output logic signed [emr_pkg::TRIG_W-1:0] o_sin_x,
    output logic signed [emr_pkg::TRIG_W-1:0] o_cos_y,
    output logic signed [emr_pkg::TRIG_W-1:0] o_sin_y,
    output logic signed [emr_pkg::TRIG_W-1:0] o_cos_z,
    output logic signed [emr_pkg::TRIG_W-1:0] o_sin_z
);

    import emr_pkg::*;

    function automatic t_trig apply_sign(t_mag m, logic neg);
        t_trig v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    // lookup order: cos x, sin x, cos y, sin y, cos z, sin z
    t_angle   w_ang [0:2];
    t_lookup  r_lk  [0:5];
    logic     r_neg [0:5];
    t_mag     w_mag [0:5];
    t_trig    w_val [0:5];

    t_tab_idx r_fill_idx;
    logic     r_ready;
    logic     n_ready;

    t_trig    r_cy_a, r_sy_a, r_cy_b, r_sy_b;
    t_trig    r_cz_a, r_sz_a, r_cz_b, r_sz_b, r_cz_c, r_sz_c, r_cz_d, r_sz_d;

    assign w_ang[0] = i_angle_x;
    assign w_ang[1] = i_angle_y;
    assign w_ang[2] = i_angle_z;

    // table fill after reset, one entry a beat
    assign n_ready = r_ready || (r_fill_idx == TAB_IDX_W'(SINE_TABLE_ENTRIES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_idx <= '0;
            r_ready    <= 1'b0;
        end else begin
            r_ready <= n_ready;
            if (!r_ready) begin
                r_fill_idx <= r_fill_idx + 1'b1;
            end
        end
    end

    assign o_ready = r_ready;

    always_ff @(posedge i_clk) begin
        if (i_en.idx) begin
            for (int a = 0; a < 3; a++) begin
                r_lk[2*a]   <= sine_lookup(ANGLE_W'(w_ang[a] + ANGLE_W'(16384)));
                r_lk[2*a+1] <= sine_lookup(w_ang[a]);
            end
        end
        if (i_en.rom) begin
            for (int i = 0; i < 6; i++) begin
                r_neg[i] <= r_lk[i].neg;
            end
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_tab
        emr_ram #(
            .WIDTH (MAG_W),
            .DEPTH (TAB_DEPTH)
        ) u_tab (
            .i_clk     (i_clk),
            .i_we      (!r_ready),
            .i_waddr   (r_fill_idx),
            .i_wdata   (SINE_TAB[r_fill_idx]),
            .i_re      (i_en.rom),
            .i_raddr_a (r_lk[2*a].idx),
            .i_raddr_b (r_lk[2*a+1].idx),
            .o_rdata_a (w_mag[2*a]),
            .o_rdata_b (w_mag[2*a+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_val[i] = apply_sign(w_mag[i], r_neg[i]);
        end
    end

    // Y terms wait for the X plane, Z terms for X and Y
    always_ff @(posedge i_clk) begin
        if (i_en.px.prod) begin
            r_cy_a <= w_val[2];
            r_sy_a <= w_val[3];
            r_cz_a <= w_val[4];
            r_sz_a <= w_val[5];
        end
        if (i_en.px.sum) begin
            r_cy_b <= r_cy_a;
            r_sy_b <= r_sy_a;
            r_cz_b <= r_cz_a;
            r_sz_b <= r_sz_a;
        end
        if (i_en.py.prod) begin
            r_cz_c <= r_cz_b;
            r_sz_c <= r_sz_b;
        end
        if (i_en.py.sum) begin
            r_cz_d <= r_cz_c;
            r_sz_d <= r_sz_c;
        end
    end

    assign o_cos_x = w_val[0];
    assign o_sin_x = w_val[1];
    assign o_cos_y = r_cy_b;
    assign o_sin_y = r_sy_b;
    assign o_cos_z = r_cz_d;
    assign o_sin_z = r_sz_d;

endmodule

// File: rtl/core/emr_plane.sv
module emr_plane (
    input  logic                 i_clk,
    input  emr_pkg::t_plane_en   i_en,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_u,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_w,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_c,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_s,
    output logic signed [emr_pkg::ELEM_W-1:0] o_u,
    output logic signed [emr_pkg::ELEM_W-1:0] o_w
);

    import emr_pkg::*;

    // round half up to Q2.16, then clamp
    function automatic t_elem round_sat(logic signed [SUM_W-1:0] v);
        logic signed [SUM_W:0]       t;
        logic signed [RND_W-1:0]     r;
        logic [RND_W-ELEM_W:0]       hi;
        t  = (SUM_W+1)'(v) + (SUM_W+1)'(32768);
        r  = t[SUM_W:16];
        hi = r[RND_W-1:ELEM_W-1];
        if (hi == '0 || hi == '1) begin
            return r[ELEM_W-1:0];
        end
        return r[RND_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
    endfunction

    logic signed [PROD_W-1:0] r_uc, r_ws, r_us, r_wc;
    t_elem                    r_u, r_w;

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            r_uc <= i_u * i_c;
            r_ws <= i_w * i_s;
            r_us <= i_u * i_s;
            r_wc <= i_w * i_c;
        end
        if (i_en.sum) begin
            r_u <= round_sat(SUM_W'(r_uc) - SUM_W'(r_ws));
            r_w <= round_sat(SUM_W'(r_us) + SUM_W'(r_wc));
        end
    end

    assign o_u = r_u;
    assign o_w = r_w;

endmodule

// File: rtl/core/emr_lane.sv
module emr_lane (
    input  logic                 i_clk,
    input  emr_pkg::t_pipe_en    i_en,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_x,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_y,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_z,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_cos_x,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_sin_x,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_cos_y,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_sin_y,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_cos_z,
    input  logic signed [emr_pkg::TRIG_W-1:0] i_sin_z,
    output logic signed [emr_pkg::ELEM_W-1:0] o_x,
    output logic signed [emr_pkg::ELEM_W-1:0] o_y,
    output logic signed [emr_pkg::ELEM_W-1:0] o_z
);

    import emr_pkg::*;

    t_elem r_x1, r_y1, r_z1, r_x2, r_y2, r_z2;
    t_elem r_xa, r_xb, r_ya, r_yb, r_za, r_zb;
    t_elem w_y3, w_z3, w_z4, w_x4, w_x5, w_y5;

    always_ff @(posedge i_clk) begin
        if (i_en.idx) begin
            r_x1 <= i_x;
            r_y1 <= i_y;
            r_z1 <= i_z;
        end
        if (i_en.rom) begin
            r_x2 <= r_x1;
            r_y2 <= r_y1;
            r_z2 <= r_z1;
        end
        if (i_en.px.prod) r_xa <= r_x2;
        if (i_en.px.sum)  r_xb <= r_xa;
        if (i_en.py.prod) r_ya <= w_y3;
        if (i_en.py.sum)  r_yb <= r_ya;
        if (i_en.pz.prod) r_za <= w_z4;
        if (i_en.pz.sum)  r_zb <= r_za;
    end

    // about X: (y, z)
    emr_plane u_px (
        .i_clk (i_clk),
        .i_en  (i_en.px),
        .i_u   (r_y2),
        .i_w   (r_z2),
        .i_c   (i_cos_x),
        .i_s   (i_sin_x),
        .o_u   (w_y3),
        .o_w   (w_z3)
    );

    // about Y: (z, x)
    emr_plane u_py (
        .i_clk (i_clk),
        .i_en  (i_en.py),
        .i_u   (w_z3),
        .i_w   (r_xb),
        .i_c   (i_cos_y),
        .i_s   (i_sin_y),
        .o_u   (w_z4),
        .o_w   (w_x4)
    );

    // about Z: (x, y)
    emr_plane u_pz (
        .i_clk (i_clk),
        .i_en  (i_en.pz),
        .i_u   (w_x4),
        .i_w   (r_yb),
        .i_c   (i_cos_z),
        .i_s   (i_sin_z),
        .o_u   (w_x5),
        .o_w   (w_y5)
    );

    assign o_x = w_x5;
    assign o_y = w_y5;
    assign o_z = r_zb;

endmodule

// File: rtl/core/euler_matrix_rotate.sv
// Rotates the three rows of a 3x3 orientation matrix about X, then Y, then Z.
// Input channel: i_valid / o_stall carry nine Q2.16 elements and three binary
// angles; a beat is taken when i_valid is high and o_stall low.
// Output channel: o_valid / i_stall carry the nine rotated, saturated elements.
// An accepted beat passes the sine table (address, registered read), each plane
// rotation (multiply, round and clamp) and the output register before o_valid.
// Throughput is one beat per cycle while neither side stalls; the six table
// reads go through two read ports on each of three table RAMs.
// Three row lanes run side by side and the output register gathers them.
// After reset the sine tables are filled from the constant table, one entry
// a cycle: o_stall stays high until SINE_TABLE_ENTRIES + 1 (1025) are written.
// When the receiver stalls, each stage holds only if the one after it is
// full, so bubbles close up; o_stall rises once all nine stages hold beats.
module euler_matrix_rotate (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row0_x,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row0_y,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row0_z,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row1_x,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row1_y,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row1_z,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row2_x,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row2_y,
    input  logic signed [emr_pkg::ELEM_W-1:0] i_row2_z,
    input  logic [emr_pkg::ANGLE_W-1:0] i_angle_x,
    input  logic [emr_pkg::ANGLE_W-1:0] i_angle_y,
    input  logic [emr_pkg::ANGLE_W-1:0] i_angle_z,
    output logic o_valid,
    input  logic i_stall,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row0_x,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row0_y,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row0_z,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row1_x,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row1_y,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row1_z,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row2_x,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row2_y,
    output logic signed [emr_pkg::ELEM_W-1:0] o_new_row2_z
);

    import emr_pkg::*;

    logic [N_STAGES-1:0] r_vld;
    logic [N_STAGES-1:0] w_en;
    t_pipe_en            w_pipe;
    logic                w_ready;
    logic                w_take;

    t_trig w_cx, w_sx, w_cy, w_sy, w_cz, w_sz;
    t_elem w_in  [0:2][0:2];
    t_elem w_out [0:2][0:2];
    t_elem r_out [0:2][0:2];

    // a stage moves when empty or when the next one moves
    always_comb begin
        w_en[N_STAGES-1] = !r_vld[N_STAGES-1] || !i_stall;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign w_pipe.idx     = w_en[0];
    assign w_pipe.rom     = w_en[1];
    assign w_pipe.px.prod = w_en[2];
    assign w_pipe.px.sum  = w_en[3];
    assign w_pipe.py.prod = w_en[4];
    assign w_pipe.py.sum  = w_en[5];
    assign w_pipe.pz.prod = w_en[6];
    assign w_pipe.pz.sum  = w_en[7];

    assign w_take  = i_valid && w_en[0] && w_ready;
    assign o_stall = !(w_en[0] && w_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= w_take;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    emr_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_pipe),
        .i_angle_x (i_angle_x),
        .i_angle_y (i_angle_y),
        .i_angle_z (i_angle_z),
        .o_ready   (w_ready),
        .o_cos_x   (w_cx),
        .o_sin_x   (w_sx),
        .o_cos_y   (w_cy),
        .o_sin_y   (w_sy),
        .o_cos_z   (w_cz),
        .o_sin_z   (w_sz)
    );

    assign w_in[0][0] = i_row0_x;
    assign w_in[0][1] = i_row0_y;
    assign w_in[0][2] = i_row0_z;
    assign w_in[1][0] = i_row1_x;
    assign w_in[1][1] = i_row1_y;
    assign w_in[1][2] = i_row1_z;
    assign w_in[2][0] = i_row2_x;
    assign w_in[2][1] = i_row2_y;
    assign w_in[2][2] = i_row2_z;

    for (genvar r = 0; r < 3; r++) begin : g_lane
        emr_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_pipe),
            .i_x     (w_in[r][0]),
            .i_y     (w_in[r][1]),
            .i_z     (w_in[r][2]),
            .i_cos_x (w_cx),
            .i_sin_x (w_sx),
            .i_cos_y (w_cy),
            .i_sin_y (w_sy),
            .i_cos_z (w_cz),
            .i_sin_z (w_sz),
            .o_x     (w_out[r][0]),
            .o_y     (w_out[r][1]),
            .o_z     (w_out[r][2])
        );
    end

    // output register gathers the three lanes into one beat
    always_ff @(posedge i_clk) begin
        if (w_en[N_STAGES-1]) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_out[r][c] <= w_out[r][c];
                end
            end
        end
    end

    assign o_valid      = r_vld[N_STAGES-1];
    assign o_new_row0_x = r_out[0][0];
    assign o_new_row0_y = r_out[0][1];
    assign o_new_row0_z = r_out[0][2];
    assign o_new_row1_x = r_out[1][0];
    assign o_new_row1_y = r_out[1][1];
    assign o_new_row1_z = r_out[1][2];
    assign o_new_row2_x = r_out[2][0];
    assign o_new_row2_y = r_out[2][1];
    assign o_new_row2_z = r_out[2][2];

endmodule

// File: dv/tb_euler_matrix_rotate.sv
module tb_euler_matrix_rotate;

    import emr_pkg::*;

    localparam int EMAX      = 131071;
    localparam int EMIN      = -131072;
    localparam int ONE       = 65536;
    localparam int N_PHASE   = 3;
    localparam int N_PER     = 417;
    localparam int LATENCY   = 9;
    localparam int MAX_CYCLE = 200000;

    typedef logic [8:0][ELEM_W-1:0] t_mat;

    typedef struct packed {
        t_mat   m;
        t_angle ax;
        t_angle ay;
        t_angle az;
    } t_rot_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic        i_stall = 1'b0;
    t_elem       i_row0_x = '0, i_row0_y = '0, i_row0_z = '0;
    t_elem       i_row1_x = '0, i_row1_y = '0, i_row1_z = '0;
    t_elem       i_row2_x = '0, i_row2_y = '0, i_row2_z = '0;
    t_angle      i_angle_x = '0, i_angle_y = '0, i_angle_z = '0;
    t_elem       o_new_row0_x, o_new_row0_y, o_new_row0_z;
    t_elem       o_new_row1_x, o_new_row1_y, o_new_row1_z;
    t_elem       o_new_row2_x, o_new_row2_y, o_new_row2_z;

    t_mat        rot_next = '0;
    t_mat        rotated_q [$];
    longint      quarter_sine [0:SINE_TABLE_ENTRIES];
    int          bad_fields = 0;
    int          beats_out = 0;
    int          cycles = 0;
    int          tx_idle = 0;
    int          rx_idle = 0;

    t_rot_job    dir_job [$];
    t_mat        dir_res [$];
    bit          dir_typed [$];

    euler_matrix_rotate dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_row0_x     (i_row0_x),
        .i_row0_y     (i_row0_y),
        .i_row0_z     (i_row0_z),
        .i_row1_x     (i_row1_x),
        .i_row1_y     (i_row1_y),
        .i_row1_z     (i_row1_z),
        .i_row2_x     (i_row2_x),
        .i_row2_y     (i_row2_y),
        .i_row2_z     (i_row2_z),
        .i_angle_x    (i_angle_x),
        .i_angle_y    (i_angle_y),
        .i_angle_z    (i_angle_z),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_new_row0_x (o_new_row0_x),
        .o_new_row0_y (o_new_row0_y),
        .o_new_row0_z (o_new_row0_z),
        .o_new_row1_x (o_new_row1_x),
        .o_new_row1_y (o_new_row1_y),
        .o_new_row1_z (o_new_row1_z),
        .o_new_row2_x (o_new_row2_x),
        .o_new_row2_y (o_new_row2_y),
        .o_new_row2_z (o_new_row2_z)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // quarter-wave entry, Taylor series in Q30, rounded to Q1.16
    function automatic longint taylor_sine(int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        int unsigned     n;
        x    = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_ENTRIES);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        n    = 1;
        while (term != 0 && n < 64) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
            n++;
        end
        if (acc < 0) begin
            acc = 0;
        end
        return (acc + 8192) >>> 14;
    endfunction

    function automatic longint sine_q16(t_angle a);
        longint unsigned v;
        longint          mag;
        v   = a[14] ? 64'(16384 - int'(a[13:0])) : 64'(a[13:0]);
        mag = quarter_sine[(v * SINE_TABLE_ENTRIES + 8192) >> 14];
        return a[15] ? -mag : mag;
    endfunction

    function automatic longint round_clamp(longint v);
        longint r;
        r = (v + 32768) >>> 16;
        if (r > EMAX) begin
            r = EMAX;
        end
        if (r < EMIN) begin
            r = EMIN;
        end
        return r;
    endfunction

    // X, then Y on (z, x), then Z, row by row; clamp after every plane
    function automatic t_mat rotate_matrix(t_rot_job j);
        longint cs [3];
        longint sn [3];
        longint e [9];
        longint a;
        longint b;
        int     iu;
        int     iw;
        t_mat   res;
        cs[0] = sine_q16(j.ax + 16'd16384);
        sn[0] = sine_q16(j.ax);
        cs[1] = sine_q16(j.ay + 16'd16384);
        sn[1] = sine_q16(j.ay);
        cs[2] = sine_q16(j.az + 16'd16384);
        sn[2] = sine_q16(j.az);
        for (int i = 0; i < 9; i++) begin
            e[i] = longint'($signed(j.m[i]));
        end
        for (int r = 0; r < 3; r++) begin
            for (int p = 0; p < 3; p++) begin
                iu = (p == 0) ? 1 : (p == 1) ? 2 : 0;
                iw = (p == 0) ? 2 : (p == 1) ? 0 : 1;
                a  = e[3 * r + iu];
                b  = e[3 * r + iw];
                e[3 * r + iu] = round_clamp(a * cs[p] - b * sn[p]);
                e[3 * r + iw] = round_clamp(a * sn[p] + b * cs[p]);
            end
        end
        for (int i = 0; i < 9; i++) begin
            res[i] = ELEM_W'(e[i]);
        end
        return res;
    endfunction

    function automatic t_mat mat3(int a0, int a1, int a2, int a3, int a4, int a5,
                                  int a6, int a7, int a8);
        t_mat r;
        r[0] = ELEM_W'(a0);
        r[1] = ELEM_W'(a1);
        r[2] = ELEM_W'(a2);
        r[3] = ELEM_W'(a3);
        r[4] = ELEM_W'(a4);
        r[5] = ELEM_W'(a5);
        r[6] = ELEM_W'(a6);
        r[7] = ELEM_W'(a7);
        r[8] = ELEM_W'(a8);
        return r;
    endfunction

    function automatic int rand_elem();
        case ($urandom_range(5))
            0: begin
                case ($urandom_range(4))
                    0: return EMIN;
                    1: return EMAX;
                    2: return 0;
                    3: return ONE;
                    default: return -ONE;
                endcase
            end
            1, 2: return int'($urandom_range(2 * ONE)) - ONE;
            default: return int'($urandom() & 32'h3FFFF);
        endcase
    endfunction

    function automatic t_angle rand_angle();
        if ($urandom_range(3) == 0) begin
            return 16'($urandom_range(3) * 16384 + $urandom_range(4) - 2);
        end
        return 16'($urandom());
    endfunction

    function automatic t_rot_job random_job();
        t_rot_job j;
        j.m  = mat3(rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                    rand_elem(), rand_elem(), rand_elem(), rand_elem());
        j.ax = rand_angle();
        j.ay = rand_angle();
        j.az = rand_angle();
        return j;
    endfunction

    task automatic add_row(input t_mat m, input int ax, input int ay, input int az,
                           input bit typed, input t_mat res);
        t_rot_job j;
        j.m  = m;
        j.ax = t_angle'(ax);
        j.ay = t_angle'(ay);
        j.az = t_angle'(az);
        dir_job.push_back(j);
        dir_res.push_back(res);
        dir_typed.push_back(typed);
    endtask

    // called on a clock edge; returns on the edge the beat is taken
    task automatic drive_job(input t_rot_job j, input t_mat want);
        while ($urandom_range(99) < tx_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_row0_x  <= j.m[0];
        i_row0_y  <= j.m[1];
        i_row0_z  <= j.m[2];
        i_row1_x  <= j.m[3];
        i_row1_y  <= j.m[4];
        i_row1_z  <= j.m[5];
        i_row2_x  <= j.m[6];
        i_row2_y  <= j.m[7];
        i_row2_z  <= j.m[8];
        i_angle_x <= j.ax;
        i_angle_y <= j.ay;
        i_angle_z <= j.az;
        rot_next  <= want;
        i_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (rotated_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= MAX_CYCLE) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin : mon
        t_mat  got;
        t_mat  want;
        string axes;
        axes = "xyz";
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_new_row2_z, o_new_row2_y, o_new_row2_x,
                   o_new_row1_z, o_new_row1_y, o_new_row1_x,
                   o_new_row0_z, o_new_row0_y, o_new_row0_x};
            if (rotated_q.size() == 0) begin
                bad_fields++;
                if (bad_fields <= 10) begin
                    $display("unexpected result beat %0d", beats_out);
                end
            end else begin
                want = rotated_q.pop_front();
                for (int f = 0; f < 9; f++) begin
                    if (got[f] !== want[f]) begin
                        bad_fields++;
                        if (bad_fields <= 10) begin
                            $display("beat %0d new_row%0d_%c: expected %0d, got %0d",
                                     beats_out, f / 3, axes[f % 3],
                                     $signed(want[f]), $signed(got[f]));
                        end
                    end
                end
            end
            beats_out++;
        end
        if (i_rst_n && i_valid && !o_stall) begin
            rotated_q.push_back(rot_next);
        end
    end

    initial begin
        t_rot_job j;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++) begin
            quarter_sine[k] = taylor_sine(k);
        end

        // zero angles leave the matrix untouched
        add_row(mat3(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0, 1,
                mat3(0, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0, 0, 0, 1,
                mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        add_row(mat3(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX), 0, 0, 0, 1,
                mat3(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX));
        add_row(mat3(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN), 0, 0, 0, 1,
                mat3(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN));
        // half turn about X: negated minimum clamps
        add_row(mat3(5, EMIN, EMAX, 5, EMIN, EMAX, 5, EMIN, EMAX), 32768, 0, 0, 1,
                mat3(5, EMAX, -EMAX, 5, EMAX, -EMAX, 5, EMAX, -EMAX));
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 16384, 0, 0, 0, '0);
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0, 16384, 0, 0, '0);
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 0, 0, 16384, 0, '0);
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 8192, 8192, 8192, 0, '0);
        add_row(mat3(EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX, EMAX),
                8192, 0, 0, 0, '0);
        add_row(mat3(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN),
                0, 8192, 24576, 0, '0);
        add_row(mat3(EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN, EMIN),
                0, 32768, 32768, 0, '0);
        add_row(mat3(EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX, EMIN, EMAX),
                65535, 65535, 65535, 0, '0);
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 49152, 32768, 16383, 0, '0);
        add_row(mat3(12345, -54321, 70000, -99999, 3, 131000, -65536, 40000, -7),
                1, 16385, 40000, 0, '0);
        add_row(mat3(-1, 1, -1, 1, -1, 1, -1, 1, -1), 32767, 32769, 49151, 0, '0);
        add_row(mat3(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 12, 65520, 21845, 0, '0);
        add_row(mat3(-ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE),
                16384, 49152, 8191, 0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle = 29;
        rx_idle = 53;
        for (int i = 0; i < dir_job.size(); i++) begin
            drive_job(dir_job[i], dir_typed[i] ? dir_res[i] : rotate_matrix(dir_job[i]));
        end
        drain();

        for (int ph = 0; ph < N_PHASE; ph++) begin
            tx_idle = (ph == 0) ? 29 : (ph == 1) ? 53 : 0;
            rx_idle = (ph == 0) ? 53 : (ph == 1) ? 29 : 0;
            for (int n = 0; n < N_PER; n++) begin
                j = random_job();
                drive_job(j, rotate_matrix(j));
            end
            drain();
        end

        repeat (4 * LATENCY) @(posedge i_clk);
        if (bad_fields == 0 && rotated_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
